// ===== hw/rtl/cial_pkg.sv =====
// Shared types and constants for the complex integer ALU.
`timescale 1ns / 1ps

package cial_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int FIELD_WIDTH   = 16;
    localparam int RESULT_WIDTH  = 33;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cial_op_t;

    typedef struct packed {
        cial_op_t                operation;
        logic [FIELD_WIDTH-1:0]  a_real;
        logic [FIELD_WIDTH-1:0]  a_imag;
        logic [FIELD_WIDTH-1:0]  b_real;
        logic [FIELD_WIDTH-1:0]  b_imag;
    } cial_in_t;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] res_real;
        logic [RESULT_WIDTH-1:0] res_imag;
        logic                    divide_by_zero;
    } cial_out_t;

    // Control that travels alongside the divider lanes.
    typedef struct packed {
        logic valid;
        logic dz;
        logic neg_re;
        logic neg_im;
    } cial_ctl_t;

endpackage

// ===== hw/rtl/cial_front.sv =====
// Product stage and combine stage that load the first divider cell.
`timescale 1ns / 1ps

module cial_front #(
    parameter int W = cial_pkg::OPERAND_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  cial_pkg::cial_in_t in_item,
    output cial_pkg::cial_ctl_t ctl,
    output logic [2*W-1:0]     dvd_re,
    output logic [2*W-1:0]     dvd_im,
    output logic [2*W-1:0]     dvs
);

    localparam int NW = 2 * W;
    localparam int PW = 2 * W + 1;
    localparam int FW = cial_pkg::FIELD_WIDTH;
    localparam int UW = (W < FW) ? W : FW;

    logic signed [W-1:0] ar, ai, br, bi;

    logic                 v1_reg;
    cial_pkg::cial_op_t   op1_reg;
    logic                 dz1_reg;
    logic signed [NW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [W:0]    as_re_reg, as_im_reg;

    logic signed [PW-1:0] val_re, val_im;
    logic [NW-1:0]        mag_re, mag_im, dvs_c;
    logic [PW-1:0]        abs_re, abs_im;

    cial_pkg::cial_ctl_t  ctl_reg, ctl_next;
    logic [NW-1:0]        dvd_re_reg, dvd_im_reg, dvs_reg;

    // Sign extend the low operand bits.
    assign ar = W'(signed'(in_item.a_real[UW-1:0]));
    assign ai = W'(signed'(in_item.a_imag[UW-1:0]));
    assign br = W'(signed'(in_item.b_real[UW-1:0]));
    assign bi = W'(signed'(in_item.b_imag[UW-1:0]));

    // Hold the valid bit of the product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    // Register the products and the part-wise sums or differences.
    always_ff @(posedge clk)
    begin
        op1_reg   <= in_item.operation;
        dz1_reg   <= (in_item.operation == cial_pkg::OP_DIV) && (br == '0) && (bi == '0);
        p_rr_reg  <= NW'(ar) * NW'(br);
        p_ii_reg  <= NW'(ai) * NW'(bi);
        p_ri_reg  <= NW'(ar) * NW'(bi);
        p_ir_reg  <= NW'(ai) * NW'(br);
        p_bb_reg  <= NW'(br) * NW'(br);
        p_cc_reg  <= NW'(bi) * NW'(bi);
        if (in_item.operation == cial_pkg::OP_SUB)
        begin
            as_re_reg <= (W+1)'(ar) - (W+1)'(br);
            as_im_reg <= (W+1)'(ai) - (W+1)'(bi);
        end
        else
        begin
            as_re_reg <= (W+1)'(ar) + (W+1)'(br);
            as_im_reg <= (W+1)'(ai) + (W+1)'(bi);
        end
    end

    // Combine products; non-divide results pass the divider with a divisor of one.
    always_comb
    begin
        val_re = '0;
        val_im = '0;
        dvs_c  = NW'(1);
        case (op1_reg)
            cial_pkg::OP_ADD, cial_pkg::OP_SUB:
            begin
                val_re = PW'(as_re_reg);
                val_im = PW'(as_im_reg);
            end
            cial_pkg::OP_MUL:
            begin
                val_re = PW'(p_rr_reg) - PW'(p_ii_reg);
                val_im = PW'(p_ri_reg) + PW'(p_ir_reg);
            end
            cial_pkg::OP_DIV:
            begin
                if (!dz1_reg)
                begin
                    val_re = PW'(p_rr_reg) + PW'(p_ii_reg);
                    val_im = PW'(p_ir_reg) - PW'(p_ri_reg);
                    dvs_c  = p_bb_reg[NW-1:0] + p_cc_reg[NW-1:0];
                end
            end
            default:
            begin
                val_re = '0;
                val_im = '0;
            end
        endcase
        abs_re = val_re[PW-1] ? (PW'(0) - val_re) : val_re;
        abs_im = val_im[PW-1] ? (PW'(0) - val_im) : val_im;
        mag_re = abs_re[NW-1:0];
        mag_im = abs_im[NW-1:0];
        ctl_next.valid  = v1_reg;
        ctl_next.dz     = dz1_reg;
        ctl_next.neg_re = val_re[PW-1];
        ctl_next.neg_im = val_im[PW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_re_reg <= mag_re;
        dvd_im_reg <= mag_im;
        dvs_reg    <= dvs_c;
    end

    assign ctl    = ctl_reg;
    assign dvd_re = dvd_re_reg;
    assign dvd_im = dvd_im_reg;
    assign dvs    = dvs_reg;

endmodule

// ===== hw/rtl/cial_cell.sv =====
// One restoring division step for both result lanes.
`timescale 1ns / 1ps

module cial_cell #(
    parameter int NW = 2 * cial_pkg::OPERAND_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cial_pkg::cial_ctl_t ctl_i,
    input  logic [NW-1:0]       rem_re_i,
    input  logic [NW-1:0]       wrk_re_i,
    input  logic [NW-1:0]       rem_im_i,
    input  logic [NW-1:0]       wrk_im_i,
    input  logic [NW-1:0]       dvs_i,
    output cial_pkg::cial_ctl_t ctl_o,
    output logic [NW-1:0]       rem_re_o,
    output logic [NW-1:0]       wrk_re_o,
    output logic [NW-1:0]       rem_im_o,
    output logic [NW-1:0]       wrk_im_o,
    output logic [NW-1:0]       dvs_o
);

    logic [NW:0]   sh_re, sh_im;
    logic [NW+1:0] df_re, df_im;
    logic [NW-1:0] rem_re_next, rem_im_next, wrk_re_next, wrk_im_next;

    cial_pkg::cial_ctl_t ctl_reg;
    logic [NW-1:0] rem_re_reg, wrk_re_reg, rem_im_reg, wrk_im_reg, dvs_reg;

    // Shift in the next dividend bit and try the subtract.
    always_comb
    begin
        sh_re = {rem_re_i, wrk_re_i[NW-1]};
        sh_im = {rem_im_i, wrk_im_i[NW-1]};
        df_re = {1'b0, sh_re} - {2'b00, dvs_i};
        df_im = {1'b0, sh_im} - {2'b00, dvs_i};
        rem_re_next = df_re[NW+1] ? sh_re[NW-1:0] : df_re[NW-1:0];
        rem_im_next = df_im[NW+1] ? sh_im[NW-1:0] : df_im[NW-1:0];
        wrk_re_next = {wrk_re_i[NW-2:0], ~df_re[NW+1]};
        wrk_im_next = {wrk_im_i[NW-2:0], ~df_im[NW+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_i;
        end
    end

    // Advance the lanes to the neighbor.
    always_ff @(posedge clk)
    begin
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        wrk_re_reg <= wrk_re_next;
        wrk_im_reg <= wrk_im_next;
        dvs_reg    <= dvs_i;
    end

    assign ctl_o    = ctl_reg;
    assign rem_re_o = rem_re_reg;
    assign wrk_re_o = wrk_re_reg;
    assign rem_im_o = rem_im_reg;
    assign wrk_im_o = wrk_im_reg;
    assign dvs_o    = dvs_reg;

endmodule

// ===== hw/rtl/complex_integer_alu_top.sv =====
// Complex integer ALU: product front end, chain of divider cells, output register.
// Pipeline: product register, combine register, one chain cell per quotient bit of the
// 2*OPERAND_WIDTH-bit divider, then the output register from which done is driven.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot stall.
// Reset clears only the valid and control registers of the pipeline; data registers are not reset.
`timescale 1ns / 1ps

module complex_integer_alu_top #(
    parameter int OPERAND_WIDTH = cial_pkg::OPERAND_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cial_pkg::cial_in_t   in,
    output logic                 done,
    output cial_pkg::cial_out_t  result
);

    localparam int NW = 2 * OPERAND_WIDTH;
    localparam int RW = cial_pkg::RESULT_WIDTH;
    localparam int XW = (NW + 1 > RW) ? NW + 1 : RW;
    localparam int LAT = NW + 3;

    cial_pkg::cial_ctl_t ctl [0:NW];
    logic [NW-1:0] rem_re [0:NW];
    logic [NW-1:0] wrk_re [0:NW];
    logic [NW-1:0] rem_im [0:NW];
    logic [NW-1:0] wrk_im [0:NW];
    logic [NW-1:0] dvs    [0:NW];

    logic signed [NW:0]  q_re, q_im;
    logic signed [XW-1:0] x_re, x_im;

    logic                 done_reg;
    cial_pkg::cial_out_t  result_reg, result_next;

    assign busy = 1'b0;

    cial_front #(.W(OPERAND_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (start && !busy),
        .in_item (in),
        .ctl     (ctl[0]),
        .dvd_re  (wrk_re[0]),
        .dvd_im  (wrk_im[0]),
        .dvs     (dvs[0])
    );

    assign rem_re[0] = '0;
    assign rem_im[0] = '0;

    // Chain one cell per quotient bit.
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        cial_cell #(.NW(NW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_i    (ctl[i]),
            .rem_re_i (rem_re[i]),
            .wrk_re_i (wrk_re[i]),
            .rem_im_i (rem_im[i]),
            .wrk_im_i (wrk_im[i]),
            .dvs_i    (dvs[i]),
            .ctl_o    (ctl[i+1]),
            .rem_re_o (rem_re[i+1]),
            .wrk_re_o (wrk_re[i+1]),
            .rem_im_o (rem_im[i+1]),
            .wrk_im_o (wrk_im[i+1]),
            .dvs_o    (dvs[i+1])
        );
    end

    // Restore the signs and wrap to the result width.
    always_comb
    begin
        q_re = ctl[NW].neg_re ? ((NW+1)'(0) - {1'b0, wrk_re[NW]}) : {1'b0, wrk_re[NW]};
        q_im = ctl[NW].neg_im ? ((NW+1)'(0) - {1'b0, wrk_im[NW]}) : {1'b0, wrk_im[NW]};
        x_re = XW'(q_re);
        x_im = XW'(q_im);
        result_next.res_real       = x_re[RW-1:0];
        result_next.res_imag       = x_im[RW-1:0];
        result_next.divide_by_zero = ctl[NW].dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl[NW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted transaction returns after the fixed latency.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after pipeline latency");

    // A zero divisor yields zero parts.
    a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |-> (result.res_real == '0 && result.res_imag == '0))
        else $error("divide by zero with nonzero result");

    // No strobe without a transaction in flight.
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl[NW].valid))
        else $error("result strobe without a transaction");

endmodule

// ===== tb/tb.sv =====
// Testbench for the complex integer ALU: random and directed operands against a predictor.
`timescale 1ns / 1ps

class cplx_scoreboard;
    cial_pkg::cial_out_t pending[$];
    int                  errors;

    function new();
        errors = 0;
    endfunction

    // Compute the expected result of one accepted transaction.
    function void note_input(cial_pkg::cial_in_t t);
        longint ar, ai, br, bi, re, im, mag;
        cial_pkg::cial_out_t r;
        ar = longint'($signed(t.a_real[cial_pkg::OPERAND_WIDTH-1:0]));
        ai = longint'($signed(t.a_imag[cial_pkg::OPERAND_WIDTH-1:0]));
        br = longint'($signed(t.b_real[cial_pkg::OPERAND_WIDTH-1:0]));
        bi = longint'($signed(t.b_imag[cial_pkg::OPERAND_WIDTH-1:0]));
        re = 0;
        im = 0;
        r.divide_by_zero = 1'b0;
        case (t.operation)
            cial_pkg::OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            cial_pkg::OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            cial_pkg::OP_MUL:
            begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
            end
            default:
            begin
                mag = br * br + bi * bi;
                if (mag == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    // SystemVerilog division truncates toward zero, as needed
                    re = (ar * br + ai * bi) / mag;
                    im = (ai * br - bi * ar) / mag;
                end
            end
        endcase
        r.res_real = re[cial_pkg::RESULT_WIDTH-1:0];
        r.res_imag = im[cial_pkg::RESULT_WIDTH-1:0];
        pending.push_back(r);
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(cial_pkg::cial_out_t got);
        cial_pkg::cial_out_t exp_r;
        if (pending.size() == 0)
        begin
            $error("unexpected result: real %0h imag %0h", got.res_real, got.res_imag);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.res_real !== exp_r.res_real)
        begin
            $error("res_real expected %0h actual %0h", exp_r.res_real, got.res_real);
            errors++;
        end
        if (got.res_imag !== exp_r.res_imag)
        begin
            $error("res_imag expected %0h actual %0h", exp_r.res_imag, got.res_imag);
            errors++;
        end
        if (got.divide_by_zero !== exp_r.divide_by_zero)
        begin
            $error("divide_by_zero expected %0b actual %0b",
                   exp_r.divide_by_zero, got.divide_by_zero);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int LATENCY = 2 * cial_pkg::OPERAND_WIDTH + 3;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    cial_pkg::cial_in_t  in;
    logic                done;
    cial_pkg::cial_out_t result;

    cplx_scoreboard sb;
    bit        run_over;

    complex_integer_alu_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .in     (in),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick an operand value, weighted toward the extremes.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive one transaction and wait until it is accepted.
    task automatic send_item(input cial_pkg::cial_op_t op, input logic [15:0] ar,
                             input logic [15:0] ai, input logic [15:0] br,
                             input logic [15:0] bi);
        start       <= 1'b1;
        in.operation <= op;
        in.a_real   <= ar;
        in.a_imag   <= ai;
        in.b_real   <= br;
        in.b_imag   <= bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold start low for a burst of idle cycles.
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
    endtask

    // Note accepted transactions and check results at each edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_input(in);
        if (rst_n && done)
            sb.check_result(result);
    end

    initial
    begin
        cial_pkg::cial_op_t op;
        int       n;
        int       wait_cycles;
        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        in    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, zero divisor.
        for (int k = 0; k < 4; k++)
        begin
            op = cial_pkg::cial_op_t'(k);
            send_item(op, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
            send_item(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_item(op, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
            send_item(op, 16'h1234, 16'hfedc, 16'h0000, 16'h0000);
        end
        send_item(cial_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
        send_item(cial_pkg::OP_DIV, 16'h0007, 16'hfff9, 16'h0002, 16'h0003);
        send_item(cial_pkg::OP_DIV, 16'hfff9, 16'h0007, 16'h0000, 16'hffff);
        send_item(cial_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(cial_pkg::OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        // Random: bursts of idling, none in the last stretch.
        for (n = 0; n < 1350; n++)
        begin
            if (n < 1150 && $urandom_range(0, 3) == 0)
                idle_burst();
            op = cial_pkg::cial_op_t'($urandom_range(0, 3));
            if (op == cial_pkg::OP_DIV && $urandom_range(0, 9) == 0)
                send_item(op, pick_operand(), pick_operand(), 16'h0000, 16'h0000);
            else
                send_item(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        end
        start <= 1'b0;

        // Drain outstanding results.
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        run_over = 1'b1;
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #2000000;
        if (!run_over)
        begin
            $display("tb: errors");
            $finish;
        end
    end
endmodule

// ===== filelist.f =====
hw/rtl/cial_pkg.sv
hw/rtl/cial_front.sv
hw/rtl/cial_cell.sv
hw/rtl/complex_integer_alu_top.sv
tb/tb.sv
